// ===== rtl/core/mkhid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkhid_pkg
// Shared types, register indexes, constants and the letter pattern table of
// the Morse key to HID keycode decoder.
// ----------------------------------------------------------------------------
package mkhid_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_LIMIT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_LIMIT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN      = 8'd3;

  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MIN = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_DOT_LIMIT    = 16'd200;
  localparam logic [CFG_DATA_W-1:0] RST_DASH_LIMIT   = 16'd800;
  localparam logic [CFG_DATA_W-1:0] RST_GAP_MIN      = 16'd800;

  localparam logic [6:0] NO_MATCH_CHAR = 7'd63;
  localparam logic [6:0] LETTER_BASE   = 7'd65;
  localparam logic [4:0] KEY_BASE      = 5'd4;
  localparam logic [1:0] SHIFT_MOD     = 2'd2;
  localparam int         NUM_LETTERS   = 26;
  localparam int         MAX_PAT_LEN   = 4;

  // Symbol count and dash bits (bit i is symbol i) of the letters A to Z.
  localparam logic [2:0] PAT_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] PAT_BITS [NUM_LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_min;
    logic [CFG_DATA_W-1:0] dot_limit;
    logic [CFG_DATA_W-1:0] dash_limit;
    logic [CFG_DATA_W-1:0] gap_min;
  } cfg_t;

  typedef struct packed {
    logic key_pressed;
    logic func;
  } in_item_t;

  typedef struct packed {
    logic [1:0] modifier;
    logic [4:0] keycode;
    logic       matched;
    logic [6:0] letter;
  } result_t;

  // Looks a symbol pattern up in the letter table. The caller passes a length
  // of zero for anything that cannot be a letter.
  function automatic result_t decode_letter(input logic [2:0] len, input logic [3:0] bits);
    result_t r;
    logic    found;
    r.letter   = NO_MATCH_CHAR;
    r.matched  = 1'b0;
    r.keycode  = 5'd0;
    r.modifier = 2'd0;
    found      = 1'b0;
    for (int k = 0; k < NUM_LETTERS; k++) begin
      if (!found && len != 3'd0 && PAT_LEN[k] == len && PAT_BITS[k] == bits) begin
        found      = 1'b1;
        r.letter   = LETTER_BASE + 7'(k);
        r.matched  = 1'b1;
        r.keycode  = KEY_BASE + 5'(k);
        r.modifier = SHIFT_MOD;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mkhid_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkhid_cfg
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module mkhid_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mkhid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mkhid_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mkhid_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_min <= mkhid_pkg::RST_DEBOUNCE_MIN;
      cfg.dot_limit    <= mkhid_pkg::RST_DOT_LIMIT;
      cfg.dash_limit   <= mkhid_pkg::RST_DASH_LIMIT;
      cfg.gap_min      <= mkhid_pkg::RST_GAP_MIN;
    end else if (cfg_valid) begin
      // Indexes beyond the register list are accepted and dropped.
      case (cfg_index)
        mkhid_pkg::REG_DEBOUNCE_MIN: cfg.debounce_min <= cfg_data;
        mkhid_pkg::REG_DOT_LIMIT:    cfg.dot_limit    <= cfg_data;
        mkhid_pkg::REG_DASH_LIMIT:   cfg.dash_limit   <= cfg_data;
        mkhid_pkg::REG_GAP_MIN:      cfg.gap_min      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mkhid_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkhid_in_reg
// Input register that holds one tick or key edge item until the core takes it.
// ----------------------------------------------------------------------------
module mkhid_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mkhid_pkg::in_item_t in_item,
  input  logic                advance,
  output logic                valid,
  output mkhid_pkg::in_item_t item
);

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/mkhid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkhid_core
// Key timing state, dot and dash classification, symbol store and letter
// decode. State moves when the held item is consumed.
// ----------------------------------------------------------------------------
module mkhid_core #(
  parameter int SYMBOL_SLOTS = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mkhid_pkg::cfg_t     cfg,
  input  logic                valid,
  input  mkhid_pkg::in_item_t item,
  input  logic                advance,
  output logic                res_needed,
  output mkhid_pkg::result_t  result
);

  localparam int DEPTH = SYMBOL_SLOTS - 1;
  localparam int CNT_W = $clog2(SYMBOL_SLOTS);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (COUNT_WIDTH > mkhid_pkg::CFG_DATA_W) ?
                         COUNT_WIDTH : mkhid_pkg::CFG_DATA_W;

  logic                   key_down, key_down_next;
  logic [COUNT_WIDTH-1:0] press_ticks, press_ticks_next;
  logic [COUNT_WIDTH-1:0] release_ticks, release_ticks_next;
  logic [DEPTH-1:0]       symbol_store, symbol_store_next;
  logic [CNT_W-1:0]       symbol_count, symbol_count_next;

  logic [CMP_W-1:0] p_ext, r_ext, deb_ext, dot_ext, dash_ext, gap_ext;
  logic             is_dot, is_dash, room, gap_done, short_enough;
  logic [2:0]       pat_len;

  always_comb begin
    p_ext    = CMP_W'(press_ticks);
    r_ext    = CMP_W'(release_ticks);
    deb_ext  = CMP_W'(cfg.debounce_min);
    dot_ext  = CMP_W'(cfg.dot_limit);
    dash_ext = CMP_W'(cfg.dash_limit);
    gap_ext  = CMP_W'(cfg.gap_min);

    // The two windows are exclusive: a dash needs p at or above dot_limit.
    is_dot   = (p_ext >= deb_ext) && (p_ext < dot_ext);
    is_dash  = (p_ext >= dot_ext) && (p_ext <= dash_ext);
    room     = symbol_count < CNT_W'(DEPTH);
    gap_done = r_ext >= gap_ext;

    // Patterns longer than four symbols never name a letter.
    short_enough = (symbol_count != '0) && (symbol_count <= CNT_W'(mkhid_pkg::MAX_PAT_LEN));
    pat_len      = short_enough ? symbol_count[2:0] : 3'd0;
    result       = mkhid_pkg::decode_letter(pat_len, symbol_store[3:0]);

    res_needed = valid && item.func && item.key_pressed && gap_done;
  end

  always_comb begin
    key_down_next      = key_down;
    press_ticks_next   = press_ticks;
    release_ticks_next = release_ticks;
    symbol_store_next  = symbol_store;
    symbol_count_next  = symbol_count;
    if (!item.func) begin
      if (key_down) begin
        if (press_ticks != '1) press_ticks_next = press_ticks + 1'b1;
      end else begin
        if (release_ticks != '1) release_ticks_next = release_ticks + 1'b1;
      end
    end else if (item.key_pressed) begin
      if (gap_done) begin
        symbol_store_next = '0;
        symbol_count_next = '0;
      end
      release_ticks_next = '0;
      key_down_next      = 1'b1;
    end else begin
      if ((is_dot || is_dash) && room) begin
        symbol_store_next[symbol_count[IDX_W-1:0]] = is_dash;
        symbol_count_next = symbol_count + 1'b1;
      end
      press_ticks_next = '0;
      key_down_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down      <= 1'b0;
      press_ticks   <= '0;
      release_ticks <= '0;
      symbol_store  <= '0;
      symbol_count  <= '0;
    end else if (advance) begin
      key_down      <= key_down_next;
      press_ticks   <= press_ticks_next;
      release_ticks <= release_ticks_next;
      symbol_store  <= symbol_store_next;
      symbol_count  <= symbol_count_next;
    end
  end

endmodule

// ===== rtl/core/mkhid_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkhid_out_reg
// Result register on the master side; holds a decoded letter until taken.
// ----------------------------------------------------------------------------
module mkhid_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  mkhid_pkg::result_t result,
  output logic               free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata
);

  mkhid_pkg::result_t held;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {1'b0, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== rtl/core/morse_key_to_hid_keycode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_to_hid_keycode_top
// Morse key timer and decoder that turns key presses into HID letter codes.
// ----------------------------------------------------------------------------
// The slave channel carries one event per transfer: tuser[0] is the kind
// (0 for a millisecond tick, 1 for a key edge) and tdata[0] tells whether the
// key went down on an edge. Ticks time the press or the gap; a release stores
// a dot or a dash, and a press after a long enough gap decodes the stored
// symbols and sends one result on the master channel.
// A decoding press goes through the input register, and its result is then
// loaded into the output register. Events are taken at one per cycle unless
// a result waits for the output register: one input register feeds the timing
// and decode logic, which feeds one output register.
// When the receiver stalls, the held result stays put; ticks and releases
// still flow, and the next decoding press waits in the input register until
// the output register empties.
// The configuration channel is always ready and writes a threshold register
// by index; unknown indexes are dropped. It is meant to be used while idle.
// Reset restores the default thresholds, releases the key, clears both
// counters and the symbol store, and empties both registers.
// ----------------------------------------------------------------------------
module morse_key_to_hid_keycode_top #(
  parameter int SYMBOL_SLOTS = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [0] key_pressed, [7:1] zero
  input  logic [0:0]                       s_tuser,   // [0] func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // [6:0] letter, [7] matched,
                                                      // [12:8] keycode, [14:13] modifier
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mkhid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkhid_pkg::CFG_DATA_W-1:0] cfg_data
);

  mkhid_pkg::cfg_t     cfg;
  mkhid_pkg::in_item_t s_item;
  mkhid_pkg::in_item_t item;
  mkhid_pkg::result_t  result;
  logic                item_valid;
  logic                advance;
  logic                res_needed;
  logic                out_free;

  assign s_item.func        = s_tuser[0];
  assign s_item.key_pressed = s_tdata[0];

  // An event that yields no result never waits on the output side.
  assign advance = item_valid && (!res_needed || out_free);

  mkhid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mkhid_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (s_item),
    .advance  (advance),
    .valid    (item_valid),
    .item     (item)
  );

  mkhid_core #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .valid      (item_valid),
    .item       (item),
    .advance    (advance),
    .res_needed (res_needed),
    .result     (result)
  );

  mkhid_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_needed),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/core/mkhid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkhid_checker
// Port-level checks of the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mkhid_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A matched letter carries shift and the keycode that follows from it.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |->
      m_tdata[14:13] == mkhid_pkg::SHIFT_MOD &&
      m_tdata[6:0] >= mkhid_pkg::LETTER_BASE &&
      m_tdata[12:8] == 5'(m_tdata[6:0] - mkhid_pkg::LETTER_BASE) + mkhid_pkg::KEY_BASE)
    else $error("matched result fields disagree");

  // An unmatched result is the question mark with no keycode.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[7] |->
      m_tdata[6:0] == mkhid_pkg::NO_MATCH_CHAR && m_tdata[12:8] == 5'd0 &&
      m_tdata[14:13] == 2'd0)
    else $error("unmatched result fields not cleared");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind morse_key_to_hid_keycode_top mkhid_checker u_mkhid_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/morse_key_to_hid_keycode_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_to_hid_keycode_top_test
// Self-checking bench for the Morse key to HID keycode decoder.
// ----------------------------------------------------------------------------
// The bench keeps its own timing and letter model of the key. It computes a
// letter for every decoding press that it hands over, and checks each letter
// transfer on the master side field by field against the oldest one that it
// still owes. A scripted opening exercises the default thresholds, counter
// saturation, the full symbol store and repeated edges. Random phases follow,
// each with its own thresholds, and mostly send whole letters built from dots,
// dashes and gaps around the current limits, mixed with stray events. Both
// sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module morse_key_to_hid_keycode_top_test;

  localparam logic       FUNC_TICK    = 1'b0;
  localparam logic       FUNC_EDGE    = 1'b1;
  localparam logic [6:0] CHAR_UNKNOWN = 7'd63;
  localparam logic [6:0] CHAR_A       = 7'd65;
  localparam logic [6:0] CHAR_E       = 7'd69;
  localparam logic [6:0] CHAR_N       = 7'd78;
  localparam logic [6:0] CHAR_T       = 7'd84;
  localparam logic [4:0] HID_A        = 5'd4;
  localparam logic [1:0] SHIFT_LEFT   = 2'd2;
  localparam int         MARK_SLOTS   = 7;
  localparam int         SCRIPT_ROWS  = 29;

  typedef enum logic [1:0] {EV_TICK, EV_PRESS, EV_RELEASE, EV_SET} step_kind_t;

  typedef struct {
    step_kind_t                       kind;
    int unsigned                      reps;   // repeat count, or the value of a write
    logic [mkhid_pkg::CFG_IDX_W-1:0]  sel;    // register index of a write
    bit                               typed;  // the last repeat owes the letter below
    logic [6:0]                       ch;
  } script_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;   // [0] key_pressed, [7:1] zero
  logic [0:0]                       s_tuser;   // [0] func
  logic                             m_tvalid;
  logic                             m_tready;
  logic [15:0]                      m_tdata;   // [6:0] letter, [7] matched,
                                               // [12:8] keycode, [14:13] modifier
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [mkhid_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mkhid_pkg::CFG_DATA_W-1:0] cfg_data;

  // Model of the key timer and the symbol store.
  logic [15:0] thr_debounce, thr_dot, thr_dash, thr_gap;
  logic        key_is_down;
  logic [15:0] held_ticks, idle_ticks;
  logic [MARK_SLOTS-1:0] dash_marks;
  logic [2:0]  mark_count;

  mkhid_pkg::result_t letters_due[$];
  int unsigned fault_count  = 0;
  int unsigned items_sent   = 0;
  bit          send_calm    = 1'b0;
  bit          rx_calm      = 1'b0;

  // The opening script starts from the default thresholds (10, 200, 800, 800).
  script_row_t opening_script [SCRIPT_ROWS] = '{
    '{EV_PRESS,   1,     8'd0, 1'b0, 7'd0},        // no gap yet, nothing decoded
    '{EV_TICK,    10,    8'd0, 1'b0, 7'd0},
    '{EV_RELEASE, 1,     8'd0, 1'b0, 7'd0},        // shortest dot
    '{EV_TICK,    800,   8'd0, 1'b0, 7'd0},
    '{EV_PRESS,   1,     8'd0, 1'b1, CHAR_E},
    '{EV_TICK,    800,   8'd0, 1'b0, 7'd0},
    '{EV_RELEASE, 1,     8'd0, 1'b0, 7'd0},        // longest dash
    '{EV_TICK,    799,   8'd0, 1'b0, 7'd0},
    '{EV_PRESS,   1,     8'd0, 1'b0, 7'd0},        // gap one tick short
    '{EV_TICK,    9,     8'd0, 1'b0, 7'd0},
    '{EV_RELEASE, 1,     8'd0, 1'b0, 7'd0},        // bounce, dropped
    '{EV_TICK,    800,   8'd0, 1'b0, 7'd0},
    '{EV_PRESS,   1,     8'd0, 1'b1, CHAR_T},
    '{EV_TICK,    801,   8'd0, 1'b0, 7'd0},
    '{EV_RELEASE, 1,     8'd0, 1'b0, 7'd0},        // too long for a dash
    '{EV_TICK,    800,   8'd0, 1'b0, 7'd0},
    '{EV_PRESS,   1,     8'd0, 1'b1, CHAR_UNKNOWN}, // empty store
    '{EV_SET,     65535, mkhid_pkg::REG_DOT_LIMIT,    1'b0, 7'd0},
    '{EV_SET,     65535, mkhid_pkg::REG_DASH_LIMIT,   1'b0, 7'd0},
    '{EV_SET,     65535, mkhid_pkg::REG_GAP_MIN,      1'b0, 7'd0},
    '{EV_SET,     0,     mkhid_pkg::REG_DEBOUNCE_MIN, 1'b0, 7'd0},
    '{EV_TICK,    65600, 8'd0, 1'b0, 7'd0},        // press counter saturates
    '{EV_RELEASE, 1,     8'd0, 1'b0, 7'd0},        // saturated press is a dash
    '{EV_RELEASE, 1,     8'd0, 1'b0, 7'd0},        // second release gives a dot
    '{EV_TICK,    65600, 8'd0, 1'b0, 7'd0},        // release counter saturates
    '{EV_PRESS,   1,     8'd0, 1'b1, CHAR_N},
    '{EV_RELEASE, 8,     8'd0, 1'b0, 7'd0},        // overfills the store with dots
    '{EV_TICK,    65600, 8'd0, 1'b0, 7'd0},
    '{EV_PRESS,   1,     8'd0, 1'b1, CHAR_UNKNOWN}  // full store
  };

  morse_key_to_hid_keycode_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Letter index of a symbol pattern (bit i set when symbol i is a dash), or -1.
  function automatic int morse_letter(input logic [2:0] len, input logic [3:0] dashes);
    case ({len, dashes})
      {3'd2, 4'd2}:  return 0;   // A .-
      {3'd4, 4'd1}:  return 1;   // B -...
      {3'd4, 4'd5}:  return 2;   // C -.-.
      {3'd3, 4'd1}:  return 3;   // D -..
      {3'd1, 4'd0}:  return 4;   // E .
      {3'd4, 4'd4}:  return 5;   // F ..-.
      {3'd3, 4'd3}:  return 6;   // G --.
      {3'd4, 4'd0}:  return 7;   // H ....
      {3'd2, 4'd0}:  return 8;   // I ..
      {3'd4, 4'd14}: return 9;   // J .---
      {3'd3, 4'd5}:  return 10;  // K -.-
      {3'd4, 4'd2}:  return 11;  // L .-..
      {3'd2, 4'd3}:  return 12;  // M --
      {3'd2, 4'd1}:  return 13;  // N -.
      {3'd3, 4'd7}:  return 14;  // O ---
      {3'd4, 4'd6}:  return 15;  // P .--.
      {3'd4, 4'd11}: return 16;  // Q --.-
      {3'd3, 4'd2}:  return 17;  // R .-.
      {3'd3, 4'd0}:  return 18;  // S ...
      {3'd1, 4'd1}:  return 19;  // T -
      {3'd3, 4'd4}:  return 20;  // U ..-
      {3'd4, 4'd8}:  return 21;  // V ...-
      {3'd3, 4'd6}:  return 22;  // W .--
      {3'd4, 4'd9}:  return 23;  // X -..-
      {3'd4, 4'd13}: return 24;  // Y -.--
      {3'd4, 4'd3}:  return 25;  // Z --..
      default:       return -1;
    endcase
  endfunction

  function automatic mkhid_pkg::result_t result_for(input int k);
    mkhid_pkg::result_t r;
    r        = '0;
    r.letter = CHAR_UNKNOWN;
    if (k >= 0) begin
      r.letter   = CHAR_A + 7'(k);
      r.matched  = 1'b1;
      r.keycode  = HID_A + 5'(k);
      r.modifier = SHIFT_LEFT;
    end
    return r;
  endfunction

  // Advances the key model by one event. Returns 1 when a letter comes out.
  function automatic bit track_key_event(input logic func, input logic down,
                                         output mkhid_pkg::result_t res);
    bit emit;
    res  = result_for(-1);
    emit = 1'b0;
    if (func == FUNC_TICK) begin
      if (key_is_down) begin
        if (held_ticks != 16'hFFFF) held_ticks++;
      end else if (idle_ticks != 16'hFFFF) begin
        idle_ticks++;
      end
    end else if (down) begin
      if (idle_ticks >= thr_gap) begin
        // Anything longer than four symbols is never a letter.
        if (mark_count >= 3'd1 && mark_count <= 3'd4) begin
          res = result_for(morse_letter(mark_count, dash_marks[3:0]));
        end
        emit       = 1'b1;
        dash_marks = '0;
        mark_count = '0;
      end
      idle_ticks  = '0;
      key_is_down = 1'b1;
    end else begin
      // The dot window is tested first; it ends where the dash window begins.
      if (mark_count < 3'(MARK_SLOTS)) begin
        if (held_ticks >= thr_debounce && held_ticks < thr_dot) begin
          dash_marks[mark_count] = 1'b0;
          mark_count++;
        end else if (held_ticks >= thr_dot && held_ticks <= thr_dash) begin
          dash_marks[mark_count] = 1'b1;
          mark_count++;
        end
      end
      held_ticks  = '0;
      key_is_down = 1'b0;
    end
    return emit;
  endfunction

  function automatic int sender_gap();
    return send_calm ? 0 : int'($urandom_range(18, 0));
  endfunction

  // Mostly keeps tick runs short; a long one gets through now and then.
  function automatic int unsigned tame(input int unsigned v);
    if (v > 64 && $urandom_range(31, 0) != 0) return $urandom_range(64, 0);
    return v;
  endfunction

  // Press length aimed at the edges of the dot and dash windows.
  function automatic int unsigned pick_hold();
    int unsigned deb, dot, dsh, v;
    deb = thr_debounce;
    dot = thr_dot;
    dsh = thr_dash;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: v = (dot > deb) ? $urandom_range(dot - 1, deb) : deb;
      4, 5, 6:    v = (dsh >= dot) ? $urandom_range(dsh, dot) : dot;
      7:          v = (deb > 0) ? deb - 1 : 0;
      8:          v = dsh + 1;
      default:    v = $urandom_range(dsh + 2, 0);
    endcase
    return tame(v);
  endfunction

  // Hands one event over. A typed row owes a fixed letter; every other event
  // owes whatever the key model produces.
  task automatic push_event(input step_kind_t kind, input bit quick,
                            input bit typed, input logic [6:0] ch);
    int                 gap;
    logic               func, key;
    bit                 emit;
    mkhid_pkg::result_t res;
    func = (kind == EV_TICK) ? FUNC_TICK : FUNC_EDGE;
    key  = (kind == EV_TICK) ? 1'($urandom) : (kind == EV_PRESS);
    gap  = quick ? 0 : sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {7'd0, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    emit = track_key_event(func, key, res);
    if (typed) begin
      letters_due.push_back(result_for((ch == CHAR_UNKNOWN) ? -1 : int'(ch - CHAR_A)));
    end else if (emit) begin
      letters_due.push_back(res);
    end
  endtask

  // Long tick runs go back to back so that saturation stays cheap.
  task automatic repeat_event(input step_kind_t kind, input int unsigned reps,
                              input bit typed = 1'b0, input logic [6:0] ch = '0);
    for (int unsigned r = 0; r < reps; r++) begin
      push_event(kind, r > 0 && reps > 64, typed && r == reps - 1, ch);
    end
  endtask

  task automatic write_reg(input logic [mkhid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mkhid_pkg::CFG_DATA_W-1:0] val);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    repeat (gap) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mkhid_pkg::REG_DEBOUNCE_MIN: thr_debounce = val;
      mkhid_pkg::REG_DOT_LIMIT:    thr_dot      = val;
      mkhid_pkg::REG_DASH_LIMIT:   thr_dash     = val;
      mkhid_pkg::REG_GAP_MIN:      thr_gap      = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops the stream, waits for every owed letter, then lets the pipeline
  // run empty so that ticks and releases still in flight have landed.
  task automatic quiesce();
    int n;
    @(negedge clk);
    s_tvalid <= 1'b0;
    for (n = 0; n < 5000 && letters_due.size() != 0; n++) @(posedge clk);
    if (letters_due.size() != 0) begin
      $error("%0d letters never arrived", letters_due.size());
      fault_count++;
      letters_due.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [15:0] deb, input logic [15:0] dot,
                                input logic [15:0] dsh, input logic [15:0] gap);
    quiesce();
    write_reg(mkhid_pkg::REG_DEBOUNCE_MIN, deb);
    write_reg(mkhid_pkg::REG_DOT_LIMIT, dot);
    write_reg(mkhid_pkg::REG_DASH_LIMIT, dsh);
    write_reg(mkhid_pkg::REG_GAP_MIN, gap);
    // An index outside the register file must change nothing.
    write_reg(8'($urandom_range(255, 4)), 16'($urandom));
  endtask

  always @(posedge clk) begin : watch_letters
    mkhid_pkg::result_t seen, want;
    if (!rst && m_tvalid && m_tready) begin
      seen = mkhid_pkg::result_t'(m_tdata[14:0]);
      if (letters_due.size() == 0) begin
        $error("unexpected letter transfer, letter %0d", seen.letter);
        fault_count++;
      end else begin
        want = letters_due.pop_front();
        if (seen.letter != want.letter) begin
          $error("letter: expected %0d, got %0d", want.letter, seen.letter);
          fault_count++;
        end
        if (seen.matched != want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, seen.matched);
          fault_count++;
        end
        if (seen.keycode != want.keycode) begin
          $error("keycode: expected %0d, got %0d", want.keycode, seen.keycode);
          fault_count++;
        end
        if (seen.modifier != want.modifier) begin
          $error("modifier: expected %0d, got %0d", want.modifier, seen.modifier);
          fault_count++;
        end
      end
    end
  end

  // Receiver: a fresh stall before every letter, none in calm phases.
  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = rx_calm ? 0 : int'($urandom_range(18, 0));
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int          ph;
    int unsigned phase_end, idle;
    bit          new_letter;
    logic [15:0] deb, dot, dsh, gap;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    thr_debounce = 16'd10;
    thr_dot      = 16'd200;
    thr_dash     = 16'd800;
    thr_gap      = 16'd800;
    key_is_down  = 1'b0;
    held_ticks   = '0;
    idle_ticks   = '0;
    dash_marks   = '0;
    mark_count   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_script[i]) begin
      if (opening_script[i].kind == EV_SET) begin
        quiesce();
        write_reg(opening_script[i].sel, 16'(opening_script[i].reps));
      end else begin
        repeat_event(opening_script[i].kind, opening_script[i].reps,
                     opening_script[i].typed, opening_script[i].ch);
      end
    end

    // The first phases pin the thresholds at their extremes; the rest draw
    // small windows, mostly in order, sometimes empty.
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        1: set_thresholds(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        2: set_thresholds(16'hFFFF, 16'd0, 16'hFFFF, 16'd2);
        default: begin
          if ($urandom_range(3, 0) != 0) begin
            deb = 16'($urandom_range(3, 1));
            dot = deb + 16'($urandom_range(4, 1));
            dsh = dot + 16'($urandom_range(6, 0));
            gap = 16'($urandom_range(10, 1));
          end else begin
            deb = 16'($urandom_range(6, 0));
            dot = 16'($urandom_range(10, 0));
            dsh = 16'($urandom_range(14, 0));
            gap = 16'($urandom_range(12, 0));
          end
          set_thresholds(deb, dot, dsh, gap);
        end
      endcase
      send_calm  = ($urandom_range(3, 0) == 0);
      rx_calm    = ($urandom_range(3, 0) == 0);
      phase_end  = items_sent + 170;
      new_letter = 1'b1;
      while (items_sent < phase_end) begin
        if ($urandom_range(9, 0) == 0) begin
          // Stray event: a lone tick, a double press or a double release.
          push_event(step_kind_t'($urandom_range(2, 0)), 1'b0, 1'b0, '0);
        end else begin
          // One symbol: the quiet time before it, the press, the hold, the release.
          // A letter ends after the gap threshold; now and then it falls one short.
          if (new_letter) begin
            idle = (thr_gap > 0 && $urandom_range(7, 0) == 0) ?
                   thr_gap - 1 : thr_gap + $urandom_range(3, 0);
          end else begin
            idle = (thr_gap > 0) ? $urandom_range(thr_gap - 1, 0) : 0;
          end
          repeat_event(EV_TICK, idle);
          repeat_event(EV_PRESS, 1);
          repeat_event(EV_TICK, pick_hold());
          repeat_event(EV_RELEASE, 1);
          new_letter = ($urandom_range(2, 0) == 0);
        end
      end
    end

    quiesce();
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mkhid_pkg.sv
rtl/core/mkhid_cfg.sv
rtl/core/mkhid_in_reg.sv
rtl/core/mkhid_core.sv
rtl/core/mkhid_out_reg.sv
rtl/core/morse_key_to_hid_keycode_top.sv
rtl/core/mkhid_checker.sv
sim/morse_key_to_hid_keycode_top_test.sv
